@@ design/hgcd_pkg.sv @@
// Shared types, constants and tables for the haversine distance pipeline.
`default_nettype none

package hgcd_pkg;

    localparam int CORDIC_ITERATIONS = 24;
    localparam int ITERS = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;
    localparam int IDX_W = 5;

    localparam int XY_W = 34;
    localparam int Z_W  = 33;

    localparam int SQ_ROOT_W = 31;
    localparam int SQ_REM_W  = 61;
    localparam int SQ_STEPS  = 31;

    localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;
    localparam logic [30:0] ONE_Q30         = 31'd1073741824;
    localparam logic [31:0] LAT_LIMIT       = 32'd377487360;
    localparam logic [31:0] LON_LIMIT       = 32'd754974720;
    localparam logic [31:0] DEG180_Q22      = 32'd754974720;
    localparam logic [31:0] DEG360_Q22      = 32'd1509949440;
    localparam logic [31:0] RAD_LO          = 32'd2010228885;
    localparam logic [2:0]  RAD_HI          = 3'd4;
    localparam logic [30:0] DIST_MAX        = 31'd1073741823;
    localparam logic [23:0] RADIUS_RESET    = 24'd6370986;

    localparam logic [29:0] ATAN_TBL [32] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
        30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
        30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
        30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
        30'd127, 30'd63, 30'd31, 30'd15, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
    };

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_t;

    typedef struct packed {
        logic [SQ_REM_W-1:0]  rem;
        logic [SQ_ROOT_W-1:0] root;
    } sqrt_t;

endpackage

`default_nettype wire

@@ design/hgcd_cordic_cell.sv @@
// One registered CORDIC micro-rotation, rotation or vectoring mode.
`default_nettype none

module hgcd_cordic_cell
    import hgcd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic             vec_mode,
    input  wire logic [IDX_W-1:0] iter,
    input  wire cordic_t          din,
    output cordic_t               dout
);

    cordic_t                cell_reg;
    cordic_t                cell_next;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  da;
    logic                   ccw;

    always_comb
    begin
        dx  = din.y >>> iter;
        dy  = din.x >>> iter;
        da  = signed'({3'b000, ATAN_TBL[iter]});
        // rotation steers on the residual angle, vectoring on the sign of y
        ccw = vec_mode ? din.y[XY_W-1] : ~din.z[Z_W-1];
        if (ccw)
        begin
            cell_next.x = din.x - dx;
            cell_next.y = din.y + dy;
            cell_next.z = din.z - da;
        end
        else
        begin
            cell_next.x = din.x + dx;
            cell_next.y = din.y - dy;
            cell_next.z = din.z + da;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

`default_nettype wire

@@ design/hgcd_sqrt_cell.sv @@
// One registered digit step of a restoring integer square root.
`default_nettype none

module hgcd_sqrt_cell
    import hgcd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [IDX_W-1:0] bit_pos,
    input  wire sqrt_t            din,
    output sqrt_t                 dout
);

    sqrt_t       cell_reg;
    sqrt_t       cell_next;
    logic [61:0] cand;

    always_comb
    begin
        // (2*root + 2^k) * 2^k against the running remainder
        cand = (62'(din.root) << (bit_pos + 5'd1)) + (62'd1 << {bit_pos, 1'b0});
        cell_next = din;
        if (62'(din.rem) >= cand)
        begin
            cell_next.rem  = din.rem - cand[SQ_REM_W-1:0];
            cell_next.root = din.root | (SQ_ROOT_W'(1) << bit_pos);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

`default_nettype wire

@@ design/haversine_great_circle_distance_unit.sv @@
// Top level: fully pipelined haversine great-circle distance unit.
// Throughput: one point pair per cycle; each CORDIC iteration and root digit is its own cell.
// The whole pipeline stalls together only while a result waits at the output register.
// Reset (rst_n low, async): clears the valid chain and loads the radius register with
// 6370986 m; datapath registers are not reset.
`default_nettype none

module haversine_great_circle_distance_unit
    import hgcd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // radius configuration
    input  wire logic         cfg_wr_en,
    input  wire logic [23:0]  cfg_wr_data,   // earth_radius_m
    // point pair in
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,       // from_lat, from_lon, to_lat, to_lon (31b each)
    // distance out
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [31:0]       m_tdata,       // distance (30b), zero pad
    output logic [0:0]        m_tuser        // range_error
);

    localparam int ROT0 = 4;                     // first rotation cell stage
    localparam int M1   = ROT0 + ITERS;          // squares / cos product
    localparam int SQ0  = M1 + 3;                // first root cell stage
    localparam int VEC0 = SQ0 + SQ_STEPS;        // first vectoring cell stage
    localparam int MUL  = VEC0 + ITERS;          // radius multiply
    localparam int LAT  = MUL + 2;               // total stages incl. output register

    logic en;
    assign en       = ~m_tvalid | m_tready;
    assign s_tready = en;

    // ---------------- radius register ----------------
    logic [23:0] radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg_wr_en)
        begin
            radius_reg <= cfg_wr_data;
        end
    end

    // ---------------- valid and range flag chain ----------------
    logic vld_reg [LAT];
    logic err_reg [1:LAT-2];
    logic err_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            err_reg[1] <= err_next;
            for (int i = 2; i < LAT - 1; i++)
            begin
                err_reg[i] <= err_reg[i-1];
            end
        end
    end

    // ---------------- stage 0: capture coordinates ----------------
    logic signed [30:0] lat1_reg, lon1_reg, lat2_reg, lon2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lat1_reg <= signed'(s_tdata[30:0]);
            lon1_reg <= signed'(s_tdata[61:31]);
            lat2_reg <= signed'(s_tdata[92:62]);
            lon2_reg <= signed'(s_tdata[123:93]);
        end
    end

    // ---------------- stage 1: bounds, magnitudes, differences ----------------
    logic signed [31:0] la1, la2, lo1, lo2, dlat_s, dlon_s;
    logic [31:0]        alat1, alat2, alon1, alon2, dlat, dlon, dlon_f;
    logic [30:0]        mag_reg [4];   // dlat, dlon (folded), |lat1|, |lat2|

    always_comb
    begin
        la1    = 32'(lat1_reg);
        la2    = 32'(lat2_reg);
        lo1    = 32'(lon1_reg);
        lo2    = 32'(lon2_reg);
        alat1  = la1[31] ? 32'(-la1) : 32'(la1);
        alat2  = la2[31] ? 32'(-la2) : 32'(la2);
        alon1  = lo1[31] ? 32'(-lo1) : 32'(lo1);
        alon2  = lo2[31] ? 32'(-lo2) : 32'(lo2);
        dlat_s = la1 - la2;
        dlon_s = lo1 - lo2;
        dlat   = dlat_s[31] ? 32'(-dlat_s) : 32'(dlat_s);
        dlon   = dlon_s[31] ? 32'(-dlon_s) : 32'(dlon_s);
        // fold the longitude gap onto the short way round
        dlon_f = (dlon > DEG180_Q22) ? (DEG360_Q22 - dlon) : dlon;
        err_next = (alat1 > LAT_LIMIT) || (alat2 > LAT_LIMIT) ||
                   (alon1 > LON_LIMIT) || (alon2 > LON_LIMIT);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg[0] <= dlat[30:0];
            mag_reg[1] <= dlon_f[30:0];
            mag_reg[2] <= alat1[30:0];
            mag_reg[3] <= alat2[30:0];
        end
    end

    // ---------------- stages 2-3: degrees to radians, split constant ----------------
    logic [62:0] plo_reg [4];
    logic [33:0] phi_reg [4];
    logic [30:0] ang_reg [4];
    logic [65:0] full [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 4; l++)
            begin
                plo_reg[l] <= 63'(mag_reg[l]) * 63'(RAD_LO);
                phi_reg[l] <= 34'(mag_reg[l]) * 34'(RAD_HI);
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            full[l] = (66'(phi_reg[l]) << 32) + 66'(plo_reg[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // half angles for the differences, full angles for the latitudes
            ang_reg[0] <= full[0][63:33];
            ang_reg[1] <= full[1][63:33];
            ang_reg[2] <= full[2][62:32];
            ang_reg[3] <= full[3][62:32];
        end
    end

    // ---------------- rotation CORDIC lanes ----------------
    cordic_t rot_d [4][ITERS+1];

    for (genvar l = 0; l < 4; l++)
    begin : g_rot_lane
        assign rot_d[l][0].x = signed'({4'b0000, CORDIC_GAIN_Q30});
        assign rot_d[l][0].y = '0;
        assign rot_d[l][0].z = signed'({2'b00, ang_reg[l]});
        for (genvar k = 0; k < ITERS; k++)
        begin : g_cell
            hgcd_cordic_cell u_cell (
                .clk      (clk),
                .en       (en),
                .vec_mode (1'b0),
                .iter     (IDX_W'(k)),
                .din      (rot_d[l][k]),
                .dout     (rot_d[l][k+1])
            );
        end
    end

    // ---------------- haversine term ----------------
    function automatic logic [30:0] clamp_q30(input logic signed [XY_W-1:0] v);
        logic [30:0] r;
        if (v[XY_W-1])
        begin
            r = '0;
        end
        else if (v > signed'(XY_W'(ONE_Q30)))
        begin
            r = ONE_Q30;
        end
        else
        begin
            r = v[30:0];
        end
        return r;
    endfunction

    logic [30:0] s1, s2, ca, cb;
    logic [61:0] p_s1, p_s2, p_cc, p_t2;
    logic [30:0] sq1_reg, sq2_reg, cc_reg, t1_reg, t2_reg, a_reg, b_reg;
    logic [31:0] a_sum;

    always_comb
    begin
        s1   = clamp_q30(rot_d[0][ITERS].y);
        s2   = clamp_q30(rot_d[1][ITERS].y);
        ca   = clamp_q30(rot_d[2][ITERS].x);
        cb   = clamp_q30(rot_d[3][ITERS].x);
        p_s1 = 62'(s1) * 62'(s1);
        p_s2 = 62'(s2) * 62'(s2);
        p_cc = 62'(ca) * 62'(cb);
        p_t2 = 62'(cc_reg) * 62'(sq2_reg);
        a_sum = 32'(t1_reg) + 32'(t2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq1_reg <= p_s1[60:30];
            sq2_reg <= p_s2[60:30];
            cc_reg  <= p_cc[60:30];
            t1_reg  <= sq1_reg;
            t2_reg  <= p_t2[60:30];
            a_reg   <= (a_sum > 32'(ONE_Q30)) ? ONE_Q30 : a_sum[30:0];
            b_reg   <= (a_sum > 32'(ONE_Q30)) ? 31'd0 : (ONE_Q30 - a_sum[30:0]);
        end
    end

    // ---------------- square roots, one result digit per cell ----------------
    sqrt_t sqa_d [SQ_STEPS+1];
    sqrt_t sqb_d [SQ_STEPS+1];

    assign sqa_d[0].rem  = {a_reg, 30'd0};
    assign sqa_d[0].root = '0;
    assign sqb_d[0].rem  = {b_reg, 30'd0};
    assign sqb_d[0].root = '0;

    for (genvar j = 0; j < SQ_STEPS; j++)
    begin : g_sqrt
        hgcd_sqrt_cell u_sqa (
            .clk     (clk),
            .en      (en),
            .bit_pos (IDX_W'(SQ_STEPS - 1 - j)),
            .din     (sqa_d[j]),
            .dout    (sqa_d[j+1])
        );
        hgcd_sqrt_cell u_sqb (
            .clk     (clk),
            .en      (en),
            .bit_pos (IDX_W'(SQ_STEPS - 1 - j)),
            .din     (sqb_d[j]),
            .dout    (sqb_d[j+1])
        );
    end

    // ---------------- vectoring CORDIC: half central angle ----------------
    cordic_t vec_d [ITERS+1];

    assign vec_d[0].x = signed'({3'b000, sqb_d[SQ_STEPS].root});
    assign vec_d[0].y = signed'({3'b000, sqa_d[SQ_STEPS].root});
    assign vec_d[0].z = '0;

    for (genvar k = 0; k < ITERS; k++)
    begin : g_vec
        hgcd_cordic_cell u_cell (
            .clk      (clk),
            .en       (en),
            .vec_mode (1'b1),
            .iter     (IDX_W'(k)),
            .din      (vec_d[k]),
            .dout     (vec_d[k+1])
        );
    end

    // ---------------- radius scale, round, saturate ----------------
    logic [30:0] z_c;
    logic [54:0] prod_reg;
    logic [55:0] rnd;
    logic [30:0] dist_full;
    logic [29:0] dist_reg;
    logic        err_out_reg;

    always_comb
    begin
        z_c       = vec_d[ITERS].z[Z_W-1] ? 31'd0 : vec_d[ITERS].z[30:0];
        rnd       = 56'(prod_reg) + (56'd1 << 24);
        dist_full = rnd[55:25];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg    <= 55'(radius_reg) * 55'(z_c);
            err_out_reg <= err_reg[LAT-2];
            if (err_reg[LAT-2])
            begin
                dist_reg <= '0;
            end
            else if (dist_full > DIST_MAX)
            begin
                dist_reg <= DIST_MAX[29:0];
            end
            else
            begin
                dist_reg <= dist_full[29:0];
            end
        end
    end

    assign m_tvalid   = vld_reg[LAT-1];
    assign m_tdata    = {2'b00, dist_reg};
    assign m_tuser[0] = err_out_reg;

    // ---------------- checks ----------------
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == 32'd0)
        else $error("range error with nonzero distance");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(vld_reg[LAT-2]))
        else $error("pipeline advanced during output stall");

    a_zero_radius: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (radius_reg == 24'd0) && $stable(radius_reg) |-> m_tdata == 32'd0)
        else $error("zero radius gave nonzero distance");

endmodule

`default_nettype wire
